@@ hw/rtl/bpv_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Battery charge lookup package
// Types, the discharge curve and the widths derived from it, shared by the
// threshold registers, the segment selection stage and the interpolator.
// ----------------------------------------------------------------------------
package bpv_pkg;

	localparam int CURVE_POINTS = 12;
	localparam int MV_W         = 16;
	localparam int PCT_W        = 7;
	localparam int SEG_W        = $clog2(CURVE_POINTS);
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 16;

	typedef logic [MV_W-1:0]  mv_t;
	typedef logic [PCT_W-1:0] pct_t;
	typedef logic [SEG_W-1:0] seg_t;

	localparam pct_t PCT_FULL     = 7'd100;
	localparam pct_t PCT_EMPTY    = 7'd0;
	localparam mv_t  WARN_RESET   = 16'd3400;
	localparam mv_t  CUTOFF_RESET = 16'd3200;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WARN   = 1'b0,
		REG_CUTOFF = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_INTERP = 2'd0,
		MODE_FULL   = 2'd1,
		MODE_EMPTY  = 2'd2
	} mode_t;

	typedef struct packed {
		mv_t warn;
		mv_t cutoff;
	} thresholds_t;

	typedef struct packed {
		mv_t   mv;
		seg_t  seg;
		mode_t mode;
		logic  low;
		logic  crit;
	} seg_item_t;

	// Discharge curve, ordered by falling voltage.
	function automatic mv_t curve_mv(input seg_t k);
		mv_t v;
		case (k)
			4'd0:    v = 16'd4200;
			4'd1:    v = 16'd4100;
			4'd2:    v = 16'd4000;
			4'd3:    v = 16'd3900;
			4'd4:    v = 16'd3800;
			4'd5:    v = 16'd3700;
			4'd6:    v = 16'd3600;
			4'd7:    v = 16'd3500;
			4'd8:    v = 16'd3400;
			4'd9:    v = 16'd3300;
			4'd10:   v = 16'd3200;
			4'd11:   v = 16'd3000;
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic pct_t curve_pct(input seg_t k);
		pct_t p;
		case (k)
			4'd0:    p = 7'd100;
			4'd1:    p = 7'd92;
			4'd2:    p = 7'd85;
			4'd3:    p = 7'd76;
			4'd4:    p = 7'd66;
			4'd5:    p = 7'd55;
			4'd6:    p = 7'd43;
			4'd7:    p = 7'd30;
			4'd8:    p = 7'd18;
			4'd9:    p = 7'd9;
			4'd10:   p = 7'd3;
			4'd11:   p = 7'd0;
			default: p = '0;
		endcase
		return p;
	endfunction

	// Voltage span of the segment whose lower point is k; zero for a flat
	// or reversed segment and for indexes that name no segment.
	function automatic int span_mv_of(input int k);
		int hi;
		int lo;
		hi = 0;
		lo = 0;
		if (k >= 1 && k < CURVE_POINTS) begin
			hi = int'(curve_mv(seg_t'(k - 1)));
			lo = int'(curve_mv(seg_t'(k)));
		end
		return (hi > lo) ? (hi - lo) : 0;
	endfunction

	function automatic int max_span_mv();
		int m;
		int d;
		m = 1;
		for (int k = 1; k < CURVE_POINTS; k++) begin
			d = span_mv_of(k);
			if (d > m) m = d;
		end
		return m;
	endfunction

	localparam int MAX_SPAN_MV = max_span_mv();
	localparam int SPAN_W      = $clog2(MAX_SPAN_MV + 1);
	localparam int ABOVE_W     = SPAN_W;
	localparam int NUM_W       = ABOVE_W + PCT_W + 1;
	// A ceiling reciprocal with this many fraction bits gives the exact
	// floor quotient for every numerator below 2**NUM_W.
	localparam int RECIP_SH    = NUM_W + SPAN_W;
	localparam int RECIP_W     = RECIP_SH + 1;
	localparam int PROD_W      = NUM_W + RECIP_W;

	typedef logic [SPAN_W-1:0]  span_t;
	typedef logic [ABOVE_W-1:0] above_t;
	typedef logic [NUM_W-1:0]   num_t;
	typedef logic [RECIP_W-1:0] recip_t;
	typedef logic [PROD_W-1:0]  prod_t;

endpackage
`default_nettype wire

@@ hw/rtl/bpv_cfg_regs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Threshold registers
// Holds the warning and cutoff thresholds written through the plain write
// port; writes to an unknown index are dropped.
// ----------------------------------------------------------------------------
module bpv_cfg_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wr_en,
	input  wire logic [bpv_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [bpv_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output bpv_pkg::thresholds_t                  thresholds
);
	import bpv_pkg::*;

	mv_t warn_q;
	mv_t cutoff_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warn_q   <= WARN_RESET;
			cutoff_q <= CUTOFF_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_WARN:   warn_q   <= mv_t'(cfg_wdata);
				REG_CUTOFF: cutoff_q <= mv_t'(cfg_wdata);
				default:    ;
			endcase
		end
	end

	assign thresholds.warn   = warn_q;
	assign thresholds.cutoff = cutoff_q;

endmodule
`default_nettype wire

@@ hw/rtl/bpv_seg_stage.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Segment selection stage
// Compares the incoming voltage with every curve point and with both
// thresholds, and registers the bracketing segment, the range mode and flags.
// ----------------------------------------------------------------------------
module bpv_seg_stage (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire bpv_pkg::thresholds_t       thresholds,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [bpv_pkg::MV_W-1:0]   in_mv,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output bpv_pkg::seg_item_t              out_item
);
	import bpv_pkg::*;

	logic      valid_s1;
	seg_item_t item_s1;
	seg_t      seg_c;
	mode_t     mode_c;

	// Lowest index whose point lies at or below the voltage; that point is
	// the lower end of the bracketing segment.
	always_comb begin
		seg_c = seg_t'(1);
		for (int k = CURVE_POINTS - 1; k >= 1; k--) begin
			if (in_mv >= curve_mv(seg_t'(k))) seg_c = seg_t'(k);
		end
	end

	always_comb begin
		if (in_mv >= curve_mv(seg_t'(0))) begin
			mode_c = MODE_FULL;
		end else if (in_mv <= curve_mv(seg_t'(CURVE_POINTS - 1))) begin
			mode_c = MODE_EMPTY;
		end else begin
			mode_c = MODE_INTERP;
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.mv   <= in_mv;
			item_s1.seg  <= seg_c;
			item_s1.mode <= mode_c;
			item_s1.low  <= in_mv < thresholds.warn;
			item_s1.crit <= in_mv < thresholds.cutoff;
		end
	end

	assign out_valid = valid_s1;
	assign out_item  = item_s1;

	// An interpolated item really lies inside the segment chosen for it.
	a_seg_brackets: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && item_s1.mode == MODE_INTERP |->
			item_s1.seg != seg_t'(0) && item_s1.mv >= curve_mv(item_s1.seg) &&
			item_s1.mv < curve_mv(item_s1.seg - seg_t'(1)))
		else $error("selected segment does not bracket the voltage");

	// A held item keeps its segment while the next stage is stalled.
	a_seg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_ready |=> valid_s1 && $stable(item_s1))
		else $error("segment stage changed a stalled item");

endmodule
`default_nettype wire

@@ hw/rtl/bpv_interp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Linear interpolator
// Three pipeline stages: offset and slope multiply with rounding term, a
// multiply by the segment's reciprocal span, then the final charge select.
// ----------------------------------------------------------------------------
module bpv_interp (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire bpv_pkg::seg_item_t      in_item,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [bpv_pkg::PCT_W-1:0]    charge,
	output logic                         low,
	output logic                         crit
);
	import bpv_pkg::*;

	localparam int TAB_N = 2 ** SEG_W;

	// Reciprocal spans, one per segment index, worked out at elaboration.
	recip_t recip_tab [TAB_N];

	for (genvar k = 0; k < TAB_N; k++) begin : g_recip
		localparam int SPAN  = span_mv_of(k);
		localparam int RECIP = (SPAN == 0) ? 0 : ((1 << RECIP_SH) + SPAN - 1) / SPAN;
		assign recip_tab[k] = recip_t'(RECIP);
	end

	// Stage 2 lookup
	span_t  span_mv_c;
	pct_t   span_pct_c;
	pct_t   lo_pct_c;
	pct_t   hi_pct_c;
	above_t above_c;
	logic   flat_c;

	always_comb begin
		span_mv_c  = span_t'(span_mv_of(int'(in_item.seg)));
		lo_pct_c   = curve_pct(in_item.seg);
		hi_pct_c   = curve_pct(in_item.seg - seg_t'(1));
		span_pct_c = hi_pct_c - lo_pct_c;
		above_c    = above_t'(in_item.mv - curve_mv(in_item.seg));
		flat_c     = (span_mv_c == '0) || (hi_pct_c < lo_pct_c);
	end

	logic   valid_s2, valid_s3, valid_s4;
	logic   ready_s2, ready_s3, ready_s4;
	num_t   num_s2;
	recip_t recip_s2;
	pct_t   lo_pct_s2, lo_pct_s3;
	logic   flat_s2, flat_s3;
	mode_t  mode_s2, mode_s3;
	logic   low_s2, low_s3, low_s4;
	logic   crit_s2, crit_s3, crit_s4;
	prod_t  prod_s3;
	pct_t   charge_s4;
	pct_t   charge_c;

	assign ready_s4 = !valid_s4 || out_ready;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign in_ready = ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s2) valid_s2 <= in_valid;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_s4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && in_valid) begin
			num_s2    <= num_t'(above_c) * num_t'(span_pct_c) + num_t'(span_mv_c >> 1);
			recip_s2  <= recip_tab[in_item.seg];
			lo_pct_s2 <= lo_pct_c;
			flat_s2   <= flat_c;
			mode_s2   <= in_item.mode;
			low_s2    <= in_item.low;
			crit_s2   <= in_item.crit;
		end
		if (ready_s3 && valid_s2) begin
			prod_s3   <= prod_t'(num_s2) * prod_t'(recip_s2);
			lo_pct_s3 <= lo_pct_s2;
			flat_s3   <= flat_s2;
			mode_s3   <= mode_s2;
			low_s3    <= low_s2;
			crit_s3   <= crit_s2;
		end
		if (ready_s4 && valid_s3) begin
			charge_s4 <= charge_c;
			low_s4    <= low_s3;
			crit_s4   <= crit_s3;
		end
	end

	always_comb begin
		case (mode_s3)
			MODE_FULL:   charge_c = PCT_FULL;
			MODE_EMPTY:  charge_c = PCT_EMPTY;
			MODE_INTERP: charge_c = flat_s3 ? lo_pct_s3 :
				lo_pct_s3 + prod_s3[RECIP_SH +: PCT_W];
			default:     charge_c = PCT_EMPTY;
		endcase
	end

	assign out_valid = valid_s4;
	assign charge    = charge_s4;
	assign low       = low_s4;
	assign crit      = crit_s4;

	a_charge_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 |-> charge_s4 <= PCT_FULL)
		else $error("charge result above full scale");

	// An item waiting behind a stalled output must not be dropped.
	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && valid_s4 && !out_ready |=> valid_s3 && valid_s4)
		else $error("item lost while the output was stalled");

endmodule
`default_nettype wire

@@ hw/rtl/battery_percent_from_voltage_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Battery state-of-charge lookup
// Converts a cell voltage in millivolts to whole percent on a fixed curve.
// ----------------------------------------------------------------------------
// One voltage sample is taken per clock cycle unless an output stall has
// backed up into the first stage. The item passes four register stages: the
// curve-point and threshold compares are registered at the input transfer
// itself, then come the offset-times-slope multiply, the multiply by the
// segment's reciprocal span and the output register. Each stage holds its
// own item, so an output stall only backs up the stages that are full and
// the input keeps taking samples into any empty stage.
// The user must write thresholds through the plain write port only while
// no sample is in flight; the block itself does not enforce this. The flags
// compare strictly below each threshold.
module battery_percent_from_voltage_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wr_en,
	input  wire logic [bpv_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [bpv_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  wire logic                             cell_valid,
	output logic                                  cell_ready,
	input  wire logic [bpv_pkg::MV_W-1:0]         cell_millivolts,
	output logic                                  result_valid,
	input  wire logic                             result_ready,
	output logic [bpv_pkg::PCT_W-1:0]             charge_percent,
	output logic                                  low_flag,
	output logic                                  critical_flag
);
	import bpv_pkg::*;

	thresholds_t thresholds;
	seg_item_t   seg_item;
	logic        seg_valid;
	logic        seg_ready;

	bpv_cfg_regs u_cfg_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.thresholds (thresholds)
	);

	bpv_seg_stage u_seg_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.thresholds (thresholds),
		.in_valid   (cell_valid),
		.in_ready   (cell_ready),
		.in_mv      (cell_millivolts),
		.out_valid  (seg_valid),
		.out_ready  (seg_ready),
		.out_item   (seg_item)
	);

	bpv_interp u_interp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (seg_valid),
		.in_ready  (seg_ready),
		.in_item   (seg_item),
		.out_valid (result_valid),
		.out_ready (result_ready),
		.charge    (charge_percent),
		.low       (low_flag),
		.crit      (critical_flag)
	);

endmodule
`default_nettype wire

@@ bench/battery_percent_from_voltage_top_tb.sv @@
// ----------------------------------------------------------------------------
// Battery state-of-charge lookup testbench
// Sends cell voltages through the valid/ready input, predicts the charge and
// both threshold flags for each transfer, and checks every result transfer
// in order. Thresholds are rewritten between phases while the block is idle,
// and the phases vary the amount of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module battery_percent_from_voltage_top_tb;

	import bpv_pkg::*;

	localparam int KNEES        = 12;
	localparam int DRAIN_CYCLES = 10;
	localparam int PHASE_ITEMS  = 205;
	localparam int MAX_REPORTS  = 40;

	typedef struct packed {
		pct_t charge;
		logic low;
		logic crit;
	} soc_result_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     cfg_wr_en = 1'b0;
	cfg_reg_t cfg_index = REG_WARN;
	mv_t      cfg_wdata = '0;
	logic     cell_valid = 1'b0;
	logic     cell_ready;
	mv_t      cell_millivolts = '0;
	logic     result_valid;
	logic     result_ready = 1'b0;
	pct_t     charge_percent;
	logic     low_flag;
	logic     critical_flag;

	// Threshold copies used by the prediction; they change only while idle.
	mv_t warn_mv   = WARN_RESET;
	mv_t cutoff_mv = CUTOFF_RESET;

	mv_t         pending_mv[$];
	soc_result_t expected_soc[$];
	soc_result_t want;
	int          send_gap_pct = 0;
	int          recv_stall_pct = 0;
	int          mismatch_count = 0;

	battery_percent_from_voltage_top u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.cell_valid      (cell_valid),
		.cell_ready      (cell_ready),
		.cell_millivolts (cell_millivolts),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.charge_percent  (charge_percent),
		.low_flag        (low_flag),
		.critical_flag   (critical_flag)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Discharge curve knees, highest voltage first.
	function automatic int knee_mv(input int k);
		case (k)
			0:       return 4200;
			1:       return 4100;
			2:       return 4000;
			3:       return 3900;
			4:       return 3800;
			5:       return 3700;
			6:       return 3600;
			7:       return 3500;
			8:       return 3400;
			9:       return 3300;
			10:      return 3200;
			default: return 3000;
		endcase
	endfunction

	function automatic int knee_pct(input int k);
		case (k)
			0:       return 100;
			1:       return 92;
			2:       return 85;
			3:       return 76;
			4:       return 66;
			5:       return 55;
			6:       return 43;
			7:       return 30;
			8:       return 18;
			9:       return 9;
			10:      return 3;
			default: return 0;
		endcase
	endfunction

	function automatic soc_result_t predict_soc(input mv_t mv);
		soc_result_t r;
		int          v;
		int          span_v;
		int          span_p;
		int          pct;
		v   = int'(mv);
		pct = 0;
		if (v >= knee_mv(0)) begin
			pct = 100;
		end else if (v > knee_mv(KNEES - 1)) begin
			// The first knee at or below the voltage closes the bracketing segment.
			for (int k = 1; k < KNEES; k++) begin
				if (v >= knee_mv(k)) begin
					span_v = knee_mv(k - 1) - knee_mv(k);
					span_p = knee_pct(k - 1) - knee_pct(k);
					if (span_v <= 0 || span_p < 0)
						pct = knee_pct(k);
					else
						pct = knee_pct(k) + ((v - knee_mv(k)) * span_p + span_v / 2) / span_v;
					break;
				end
			end
		end
		r.charge = pct_t'(pct);
		r.low    = (mv < warn_mv);
		r.crit   = (mv < cutoff_mv);
		return r;
	endfunction

	function automatic mv_t random_cell_mv();
		int pick;
		int v;
		pick = $urandom_range(99);
		if (pick < 60) begin
			v = $urandom_range(4300, 2900);
		end else if (pick < 75) begin
			v = $urandom_range(65535);
		end else if (pick < 88) begin
			v = knee_mv($urandom_range(KNEES - 1)) + $urandom_range(6) - 3;
		end else begin
			v = ($urandom_range(1) != 0) ? int'(warn_mv) : int'(cutoff_mv);
			v = v + $urandom_range(4) - 2;
		end
		if (v < 0) v = 0;
		if (v > 65535) v = 65535;
		return mv_t'(v);
	endfunction

	task automatic report_mismatch(input string field, input int exp_v, input int got_v);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, got_v);
	endtask

	task automatic write_threshold(input cfg_reg_t idx, input mv_t value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		if (idx == REG_WARN)
			warn_mv = value;
		else
			cutoff_mv = value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Sampling at the falling edge keeps clear of the updates at the rising one.
	task automatic wait_drained();
		@(negedge clk);
		while (pending_mv.size() != 0 || cell_valid || expected_soc.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_random(input int gap, input int stall, input int count);
		send_gap_pct   = gap;
		recv_stall_pct = stall;
		repeat (count) pending_mv.push_back(random_cell_mv());
		wait_drained();
	endtask

	// Sender: a new voltage goes out only once the previous transfer is done.
	always @(posedge clk) begin
		if (!arst_n) begin
			cell_valid <= 1'b0;
		end else if (!cell_valid || cell_ready) begin
			if (pending_mv.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
				cell_valid      <= 1'b1;
				cell_millivolts <= pending_mv.pop_front();
			end else begin
				cell_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			result_ready <= 1'b0;
		else
			result_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// The result check comes first, so a result never meets the expectation of
	// a voltage taken at the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (expected_soc.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("%0t: unexpected result, expected none, got %0d %0b %0b",
							$time, charge_percent, low_flag, critical_flag);
				end else begin
					want = expected_soc.pop_front();
					if (charge_percent !== want.charge)
						report_mismatch("charge_percent", want.charge, charge_percent);
					if (low_flag !== want.low)
						report_mismatch("low_flag", want.low, low_flag);
					if (critical_flag !== want.crit)
						report_mismatch("critical_flag", want.crit, critical_flag);
				end
			end
			if (cell_valid && cell_ready)
				expected_soc.push_back(predict_soc(cell_millivolts));
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Curve ends, knees, segment middles, the rounding tie in the bottom
		// segment, the reset thresholds and the extremes of the field.
		pending_mv = '{16'd0, 16'd65535, 16'd32768, 16'd4201, 16'd4200, 16'd4199,
			16'd4150, 16'd4100, 16'd4000, 16'd3950, 16'd3850, 16'd3750, 16'd3650,
			16'd3550, 16'd3450, 16'd3400, 16'd3399, 16'd3350, 16'd3250, 16'd3200,
			16'd3199, 16'd3100, 16'd3001, 16'd3000, 16'd2999};
		wait_drained();

		write_threshold(REG_WARN, 16'd3500);
		write_threshold(REG_CUTOFF, 16'd3300);
		run_random(0, 0, PHASE_ITEMS);

		// Extremes with the cutoff above the warning level.
		write_threshold(REG_WARN, 16'd0);
		write_threshold(REG_CUTOFF, 16'd65535);
		run_random(49, 0, PHASE_ITEMS);

		write_threshold(REG_WARN, 16'd65535);
		write_threshold(REG_CUTOFF, 16'd0);
		run_random(0, 49, PHASE_ITEMS);

		write_threshold(REG_WARN, 16'd3700);
		write_threshold(REG_CUTOFF, 16'd3900);
		run_random(19, 19, PHASE_ITEMS);

		// The sender holds off between the two halves until the pipeline is empty.
		write_threshold(REG_WARN, WARN_RESET);
		write_threshold(REG_CUTOFF, CUTOFF_RESET);
		run_random(19, 19, PHASE_ITEMS / 2);
		run_random(0, 0, PHASE_ITEMS - PHASE_ITEMS / 2);

		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#(20 * 400000);
		$display("TEST FAILED");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/bpv_pkg.sv
hw/rtl/bpv_cfg_regs.sv
hw/rtl/bpv_seg_stage.sv
hw/rtl/bpv_interp.sv
hw/rtl/battery_percent_from_voltage_top.sv
bench/battery_percent_from_voltage_top_tb.sv
